// ===== rtl/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants
// Payload structs, the descriptor that passes from the classifier to the
// piece emitter, piece side codes and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  localparam int EDGE_W = 18;
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int REM_W  = 5;

  localparam logic [2:0] SIDE_SRC = 3'd0;
  localparam logic [2:0] SIDE_TOP = 3'd1;
  localparam logic [2:0] SIDE_BOT = 3'd2;
  localparam logic [2:0] SIDE_LFT = 3'd3;
  localparam logic [2:0] SIDE_RGT = 3'd4;

  localparam logic [REM_W-1:0] REM_NONE = 5'b00000;
  localparam logic [REM_W-1:0] REM_SRC  = 5'b00001;
  localparam logic [REM_W-1:0] REM_TOP  = 5'b00010;
  localparam logic [REM_W-1:0] REM_BOT  = 5'b00100;
  localparam logic [REM_W-1:0] REM_LFT  = 5'b01000;
  localparam logic [REM_W-1:0] REM_RGT  = 5'b10000;

  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef struct packed {
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [14:0]        src_width;
    logic [14:0]        src_height;
    logic signed [15:0] cut_x;
    logic signed [15:0] cut_y;
    logic [14:0]        cut_width;
    logic [14:0]        cut_height;
  } rss_in_t;

  typedef struct packed {
    logic signed [15:0] piece_x;
    logic signed [15:0] piece_y;
    logic [14:0]        piece_width;
    logic [14:0]        piece_height;
    logic [2:0]         piece_side;
    logic               last_piece;
  } rss_out_t;

  typedef struct packed {
    logic [15:0]      src_x;
    logic [15:0]      src_y;
    logic [14:0]      src_w;
    logic [14:0]      src_h;
    logic [14:0]      top_h;
    logic [15:0]      bot_y;
    logic [14:0]      bot_h;
    logic [14:0]      lft_w;
    logic [15:0]      mid_y;
    logic [14:0]      mid_h;
    logic [15:0]      rgt_x;
    logic [14:0]      rgt_w;
    logic [REM_W-1:0] rem;
  } rss_desc_t;

endpackage

`default_nettype wire

// ===== rtl/rss_front.sv =====
// ----------------------------------------------------------------------------
// rss_front: classifier
// Three-stage pipeline that forms the edges, tests cover and overlap, trims
// the source and builds one descriptor of pieces per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_front import rss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire rss_in_t   in_data,
  input  wire logic      q_full,
  output logic           q_push,
  output rss_desc_t      q_desc
);

  function automatic edge_t sx16(input logic [15:0] v);
    return $signed({{(EDGE_W-16){v[15]}}, v});
  endfunction

  function automatic edge_t zx15(input logic [14:0] v);
    return $signed({{(EDGE_W-15){1'b0}}, v});
  endfunction

  function automatic logic [14:0] clamp15(input edge_t v);
    return v[EDGE_W-1] ? 15'd1 : v[14:0];
  endfunction

  // stage A
  logic    a_v_r;
  rss_in_t a_r;
  // stage B
  logic    b_v_r;
  rss_in_t b_r;
  edge_t   b_cr_r, b_cb_r, b_sre_r, b_sbe_r;
  // stage C
  logic        c_v_r;
  rss_in_t     c_r;
  logic        c_cover_r, c_nover_r, c_top_r, c_lft_r;
  logic [14:0] c_ph_t_r, c_pw_l_r;
  logic [15:0] c_sy1_r, c_sx1_r;
  logic [14:0] c_sh1_r, c_sw1_r;
  edge_t       c_cr_r, c_cb_r;

  logic a_free, b_free, c_free, c_done;

  // stage A logic
  edge_t a_cr, a_cb, a_sre, a_sbe;
  always_comb begin
    a_cr  = sx16(a_r.cut_x) + zx15(a_r.cut_width);
    a_cb  = sx16(a_r.cut_y) + zx15(a_r.cut_height);
    a_sre = sx16(a_r.src_x) + zx15(a_r.src_width);
    a_sbe = sx16(a_r.src_y) + zx15(a_r.src_height);
  end

  // stage B logic
  edge_t b_sx, b_sy, b_cx, b_cy, b_sw, b_sh;
  edge_t b_ph_t, b_pw_l, b_sh1r, b_sw1r;
  logic  b_cover, b_nover, b_top, b_lft;
  always_comb begin
    b_sx    = sx16(b_r.src_x);
    b_sy    = sx16(b_r.src_y);
    b_cx    = sx16(b_r.cut_x);
    b_cy    = sx16(b_r.cut_y);
    b_sw    = zx15(b_r.src_width);
    b_sh    = zx15(b_r.src_height);
    b_cover = (b_sx >= b_cx) && (b_sre_r <= b_cr_r) &&
              (b_sy >= b_cy) && (b_sbe_r <= b_cb_r);
    b_nover = (b_sx >= b_cr_r) || (b_sre_r <= b_cx) ||
              (b_sy >= b_cb_r) || (b_sbe_r <= b_cy);
    b_top   = b_sy < b_cy;
    b_lft   = b_sx < b_cx;
    b_ph_t  = b_cy - b_sy;
    b_pw_l  = b_cx - b_sx;
    b_sh1r  = b_top ? (b_sbe_r - b_cy) : b_sh;
    b_sw1r  = b_lft ? (b_sre_r - b_cx) : b_sw;
  end

  // stage C logic
  edge_t          c_d_v, c_d_h, c_sh2r;
  logic           c_bot, c_rgt;
  logic [14:0]    c_sh2;
  logic [REM_W-1:0] c_rem;
  always_comb begin
    c_d_v  = sx16(c_sy1_r) + zx15(c_sh1_r) - c_cb_r;
    c_d_h  = sx16(c_sx1_r) + zx15(c_sw1_r) - c_cr_r;
    c_bot  = c_d_v > $signed({EDGE_W{1'b0}});
    c_rgt  = c_d_h > $signed({EDGE_W{1'b0}});
    c_sh2r = c_cb_r - sx16(c_sy1_r);
    c_sh2  = c_bot ? clamp15(c_sh2r) : c_sh1_r;
    if (c_cover_r) begin
      c_rem = REM_NONE;
    end else if (c_nover_r) begin
      c_rem = REM_SRC;
    end else begin
      c_rem = (c_top_r ? REM_TOP : REM_NONE) | (c_bot ? REM_BOT : REM_NONE) |
              (c_lft_r ? REM_LFT : REM_NONE) | (c_rgt ? REM_RGT : REM_NONE);
    end
  end

  always_comb begin
    q_desc.src_x = c_r.src_x;
    q_desc.src_y = c_r.src_y;
    q_desc.src_w = c_r.src_width;
    q_desc.src_h = c_r.src_height;
    q_desc.top_h = c_ph_t_r;
    q_desc.bot_y = c_cb_r[15:0];
    q_desc.bot_h = c_d_v[14:0];
    q_desc.lft_w = c_pw_l_r;
    q_desc.mid_y = c_sy1_r;
    q_desc.mid_h = c_sh2;
    q_desc.rgt_x = c_cr_r[15:0];
    q_desc.rgt_w = c_d_h[14:0];
    q_desc.rem   = c_rem;
  end

  // drop a covered source without a queue slot
  assign c_done   = c_v_r && ((c_rem == REM_NONE) || !q_full);
  assign c_free   = !c_v_r || c_done;
  assign b_free   = !b_v_r || c_free;
  assign a_free   = !a_v_r || b_free;
  assign in_stall = !a_free;
  assign q_push   = c_v_r && (c_rem != REM_NONE) && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_free) a_v_r <= in_valid;
      if (b_free) b_v_r <= a_v_r;
      if (c_free) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_r <= in_data;
    end
    if (b_free) begin
      b_r     <= a_r;
      b_cr_r  <= a_cr;
      b_cb_r  <= a_cb;
      b_sre_r <= a_sre;
      b_sbe_r <= a_sbe;
    end
    if (c_free) begin
      c_r       <= b_r;
      c_cover_r <= b_cover;
      c_nover_r <= b_nover;
      c_top_r   <= b_top;
      c_lft_r   <= b_lft;
      c_ph_t_r  <= b_ph_t[14:0];
      c_pw_l_r  <= b_pw_l[14:0];
      c_sy1_r   <= b_top ? b_r.cut_y : b_r.src_y;
      c_sx1_r   <= b_lft ? b_r.cut_x : b_r.src_x;
      c_sh1_r   <= clamp15(b_sh1r);
      c_sw1_r   <= clamp15(b_sw1r);
      c_cr_r    <= b_cr_r;
      c_cb_r    <= b_cb_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rss_fifo.sv =====
// ----------------------------------------------------------------------------
// rss_fifo: descriptor queue
// Short flop-based queue between the classifier and the piece emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_fifo import rss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire rss_desc_t push_desc,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output rss_desc_t      head
);

  rss_desc_t          mem_r [QDEPTH];
  logic [QPW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]     cnt_r;

  function automatic logic [QPW-1:0] bump(input logic [QPW-1:0] p);
    return (p == QPW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = cnt_r == QCW'(QDEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full descriptor queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty descriptor queue");

endmodule

`default_nettype wire

// ===== rtl/rss_back.sv =====
// ----------------------------------------------------------------------------
// rss_back: piece emitter
// Walks the pending pieces of one descriptor, one beat per cycle unless
// out_stall holds the output, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_back import rss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire rss_desc_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output rss_out_t       out_data
);

  logic             cur_v_r;
  rss_desc_t        cur_r;
  logic [REM_W-1:0] rem_r;
  logic             out_valid_r;
  rss_out_t         out_data_r;

  logic             slot_free, emit, finish, load;
  logic [REM_W-1:0] pick, rest;
  rss_out_t         piece;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = cur_v_r && slot_free;
  assign pick      = rem_r & (~rem_r + 1'b1);
  assign rest      = rem_r & ~pick;
  assign finish    = emit && (rest == REM_NONE);
  assign load      = !q_empty && (!cur_v_r || finish);
  assign q_pop     = load;

  always_comb begin
    piece.last_piece = rest == REM_NONE;
    unique case (pick)
      REM_TOP: begin
        piece.piece_x      = cur_r.src_x;
        piece.piece_y      = cur_r.src_y;
        piece.piece_width  = cur_r.src_w;
        piece.piece_height = cur_r.top_h;
        piece.piece_side   = SIDE_TOP;
      end
      REM_BOT: begin
        piece.piece_x      = cur_r.src_x;
        piece.piece_y      = cur_r.bot_y;
        piece.piece_width  = cur_r.src_w;
        piece.piece_height = cur_r.bot_h;
        piece.piece_side   = SIDE_BOT;
      end
      REM_LFT: begin
        piece.piece_x      = cur_r.src_x;
        piece.piece_y      = cur_r.mid_y;
        piece.piece_width  = cur_r.lft_w;
        piece.piece_height = cur_r.mid_h;
        piece.piece_side   = SIDE_LFT;
      end
      REM_RGT: begin
        piece.piece_x      = cur_r.rgt_x;
        piece.piece_y      = cur_r.mid_y;
        piece.piece_width  = cur_r.rgt_w;
        piece.piece_height = cur_r.mid_h;
        piece.piece_side   = SIDE_RGT;
      end
      default: begin
        piece.piece_x      = cur_r.src_x;
        piece.piece_y      = cur_r.src_y;
        piece.piece_width  = cur_r.src_w;
        piece.piece_height = cur_r.src_h;
        piece.piece_side   = SIDE_SRC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      rem_r       <= REM_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cur_v_r <= 1'b1;
        rem_r   <= q_head.rem;
      end else if (emit) begin
        cur_v_r <= !finish;
        rem_r   <= rest;
      end
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r      <= q_head;
    if (emit) out_data_r <= piece;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cur_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (rem_r != REM_NONE)) else $error("active descriptor with no pieces");

  a_pieces_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_data_r.last_piece) |=> out_valid_r)
    else $error("gap inside one source's pieces");

endmodule

`default_nettype wire

// ===== rtl/rectangle_subtract_split.sv =====
// ----------------------------------------------------------------------------
// rectangle_subtract_split: source minus cut, split into pieces
// The first piece passes stages A, B, C, the queue, the descriptor register
// and the output register. Throughput: one input beat per cycle unless in_stall;
// one piece per cycle out unless out_stall; an input yields 1 to 4 pieces.
// A fully covered source yields no beat and uses no queue slot.
// Reset: synchronous active-low rst_n clears all valid flags and pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_subtract_split import rss_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire rss_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output rss_out_t     out_data
);

  logic      q_push, q_full, q_pop, q_empty;
  rss_desc_t q_desc, q_head;

  rss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (q_desc)
  );

  rss_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  rss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
